FILE: rtl/time_dependent_shortest_path_defines.svh
// ----------------------------------------------------------------------------
// time_dependent_shortest_path_defines
// assertion macros shared by the rtl files
// ----------------------------------------------------------------------------
`ifndef TIME_DEPENDENT_SHORTEST_PATH_DEFINES_SVH
`define TIME_DEPENDENT_SHORTEST_PATH_DEFINES_SVH

`ifndef SYNTHESIS
`define TDSP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define TDSP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TDSP_ASSERT(lbl, prop, msg)
`define TDSP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/tdsp_pkg.sv
// ----------------------------------------------------------------------------
// tdsp_pkg
// types and constants of the time dependent shortest path engine
// ----------------------------------------------------------------------------
package tdsp_pkg;

    localparam int NODE_W = 6;
    localparam int CNT_W  = 7;
    localparam int DIST_W = 48;
    localparam int COST_W = 32;
    localparam int DIV_W  = 50;
    localparam int IN_W   = 88;
    localparam int OUT_W  = 64;

    localparam logic [DIST_W-1:0] DIST_SAT = 48'hFFFF_FFFF_FFFE;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_RUN   = 2'd2,
        OP_NOP   = 2'd3
    } opcode_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_SEL_RD,
        S_SEL_CMP,
        S_SEL_END,
        S_EDGE_RD,
        S_EDGE_CHK,
        S_COST_WAIT,
        S_RELAX,
        S_OUT_RD,
        S_OUT_LD
    } ctrl_state_t;

    typedef enum logic [2:0] {
        C_IDLE,
        C_SQRT,
        C_W,
        C_DIV1,
        C_DIV2,
        C_SUM,
        C_SAT
    } cost_state_t;

    typedef struct packed {
        logic [COST_W-1:0] decay;
        logic [COST_W-1:0] fixed;
        logic [NODE_W-1:0] dst;
        logic [NODE_W-1:0] origin;
    } edge_t;

    typedef struct packed {
        logic [DIST_W-1:0] arrival;
        logic [NODE_W-1:0] prev;
    } node_t;

    typedef struct packed {
        logic accept;
        logic run_init;
        logic scan_clr;
        logic scan_step;
        logic best_cmp;
        logic fin_set;
        logic edge_clr;
        logic edge_step;
        logic cost_start;
        logic rd_dst;
        logic relax;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic scan_last;
        logic best_valid;
        logic edge_done;
        logic edge_match;
        logic cost_done;
        logic out_free;
    } status_t;

endpackage

FILE: rtl/time_dependent_shortest_path.sv
// add, clear and nop: result registered in the cycle after the item is taken, next item taken as it leaves
// run: per settled node a selection pass over the n nodes in use and a scan of every stored edge,
// with a cost run per matching edge (16 root steps, 2x32 divide steps, sum, relax)
// then a final selection pass and one result per node, held while the output stalls; one item at a time
// reset: edge store empty, node_count 64, no clearing pass
// ----------------------------------------------------------------------------
// time_dependent_shortest_path
// time dependent shortest path engine top level
// ----------------------------------------------------------------------------
module time_dependent_shortest_path
#(
    parameter int MAX_NODES     = 64,
    parameter int EDGE_CAPACITY = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // source node, target node, fixed cost, decay cost, run start node, zero pad
    input  logic [87:0] s_axis_tdata,
    // opcode
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // node_index, reachable, distance, predecessor, has_predecessor, zero pad
    output logic [63:0] m_axis_tdata,
    // status
    output logic [0:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data
);
    import tdsp_pkg::*;

    cmd_t    cmd;
    status_t st;

    tdsp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_op    (s_axis_tuser),
        .st       (st),
        .cmd      (cmd)
    );

    tdsp_dp
    #(
        .MAX_NODES     (MAX_NODES),
        .EDGE_CAPACITY (EDGE_CAPACITY)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .in_op     (s_axis_tuser),
        .in_data   (s_axis_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser[0]),
        .out_last  (m_axis_tlast)
    );
endmodule

FILE: rtl/tdsp_cost.sv
// ----------------------------------------------------------------------------
// tdsp_cost
// departure cost unit: iterative square root, two restoring divides, sum
// ----------------------------------------------------------------------------
module tdsp_cost
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [tdsp_pkg::DIST_W-1:0] t,
    input  logic [tdsp_pkg::COST_W-1:0] c,
    input  logic [tdsp_pkg::COST_W-1:0] d,
    output logic                        done,
    output logic [tdsp_pkg::DIST_W-1:0] nd
);
    import tdsp_pkg::*;

    cost_state_t       state_reg, state_next;
    logic [4:0]        cnt_reg;
    logic [DIST_W-1:0] t_reg;
    logic [COST_W-1:0] c_reg, d_reg;
    logic [31:0]       v_reg, res_reg, bit_reg;
    logic [15:0]       w_reg;
    logic [DIV_W-1:0]  div_reg;
    logic [31:0]       rem_reg, quo_reg, q1_reg;
    logic [34:0]       cost_reg;
    logic [DIST_W-1:0] nd_reg;
    logic              done_reg;

    logic [31:0]       sq_sum;
    logic [32:0]       div_sh;
    logic              div_ge;
    logic [15:0]       s_m1;
    logic [33:0]       a_sum, b_sum, m_sum;
    logic [DIV_W-1:0]  nd_full;

    assign sq_sum  = res_reg + bit_reg;
    assign div_sh  = {rem_reg, quo_reg[31]};
    assign div_ge  = {{(DIV_W-33){1'b0}}, div_sh} >= div_reg;
    assign s_m1    = res_reg[15:0] - 16'd1;
    assign a_sum   = {18'b0, w_reg} + {2'b0, q1_reg};
    assign b_sum   = {18'b0, w_reg} + {2'b0, quo_reg} + 34'd1;
    assign m_sum   = (a_sum < b_sum) ? a_sum : b_sum;
    assign nd_full = {2'b0, t_reg} + {15'b0, cost_reg};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            C_IDLE:  if (start) state_next = C_SQRT;
            C_SQRT:  if (cnt_reg == 5'd15) state_next = C_W;
            C_W:     state_next = C_DIV1;
            C_DIV1:  if (cnt_reg == 5'd31) state_next = C_DIV2;
            C_DIV2:  if (cnt_reg == 5'd31) state_next = C_SUM;
            C_SUM:   state_next = C_SAT;
            C_SAT:   state_next = C_IDLE;
            default: state_next = C_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == C_SAT);
            if (state_reg == C_SQRT || state_reg == C_DIV1 || state_reg == C_DIV2)
                cnt_reg <= cnt_reg + 5'd1;
            else
                cnt_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            C_IDLE:
            begin
                t_reg   <= t;
                c_reg   <= c;
                d_reg   <= d;
                v_reg   <= d;
                res_reg <= '0;
                bit_reg <= 32'h4000_0000;
            end
            C_SQRT:
            begin
                if (v_reg >= sq_sum)
                begin
                    v_reg   <= v_reg - sq_sum;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                    res_reg <= res_reg >> 1;
                bit_reg <= bit_reg >> 2;
            end
            C_W:
            begin
                if (res_reg[15:0] != 16'd0 && {32'b0, s_m1} > t_reg)
                begin
                    w_reg   <= s_m1 - t_reg[15:0];
                    div_reg <= {2'b0, t_reg} + {34'b0, s_m1 - t_reg[15:0]} + 50'd1;
                end
                else
                begin
                    w_reg   <= '0;
                    div_reg <= {2'b0, t_reg} + 50'd1;
                end
                rem_reg <= '0;
                quo_reg <= d_reg;
            end
            C_DIV1, C_DIV2:
            begin
                if (state_reg == C_DIV1 && cnt_reg == 5'd31)
                begin
                    q1_reg  <= {quo_reg[30:0], div_ge};
                    rem_reg <= '0;
                    quo_reg <= d_reg;
                    div_reg <= div_reg + 50'd1;
                end
                else
                begin
                    if (div_ge)
                        rem_reg <= div_sh[31:0] - div_reg[31:0];
                    else
                        rem_reg <= div_sh[31:0];
                    quo_reg <= {quo_reg[30:0], div_ge};
                end
            end
            C_SUM:
                cost_reg <= {3'b0, c_reg} + {1'b0, m_sum};
            C_SAT:
                nd_reg <= (nd_full > {2'b0, DIST_SAT}) ? DIST_SAT : nd_full[DIST_W-1:0];
            default: ;
        endcase
    end

    assign done = done_reg;
    assign nd   = nd_reg;

    `include "time_dependent_shortest_path_defines.svh"

    `TDSP_ASSERT_NEXT(a_cost_sat, state_reg == C_SAT, nd_reg <= DIST_SAT, "cost over saturation")
    `TDSP_ASSERT(a_cost_done, done_reg |-> $past(state_reg) == C_SAT, "stray cost done")
endmodule

FILE: rtl/tdsp_dp.sv
// ----------------------------------------------------------------------------
// tdsp_dp
// datapath: edge store, node table, selection, relaxation and result register
// ----------------------------------------------------------------------------
module tdsp_dp
#(
    parameter int MAX_NODES     = 64,
    parameter int EDGE_CAPACITY = 256
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  tdsp_pkg::cmd_t             cmd,
    output tdsp_pkg::status_t          st,
    input  logic [1:0]                 in_op,
    input  logic [tdsp_pkg::IN_W-1:0]  in_data,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [tdsp_pkg::CNT_W-1:0] cfg_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [tdsp_pkg::OUT_W-1:0] out_data,
    output logic                       out_user,
    output logic                       out_last
);
    import tdsp_pkg::*;

    localparam int NAW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int EAW = $clog2(EDGE_CAPACITY);
    localparam int ETW = $clog2(EDGE_CAPACITY + 1);

    edge_t             emem [EDGE_CAPACITY];
    node_t             nmem [MAX_NODES];

    logic [CNT_W-1:0]  node_count_reg;
    logic [ETW-1:0]    total_reg;
    logic [ETW-1:0]    e_reg;
    edge_t             edge_rd_reg;
    node_t             node_rd_reg;
    logic [CNT_W-1:0]  n_reg;
    logic [NODE_W-1:0] start_reg;
    logic [NODE_W-1:0] i_reg;
    logic [MAX_NODES-1:0] reached_reg, fin_reg;
    logic              best_valid_reg;
    logic [NODE_W-1:0] best_idx_reg;
    logic [DIST_W-1:0] best_dist_reg;
    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_data_reg;
    logic              out_user_reg, out_last_reg;

    opcode_t           op;
    edge_t             in_edge;
    logic [NODE_W-1:0] in_start;
    logic [CNT_W-1:0]  n_clamp;
    logic              full;
    logic              start_ok;
    logic              cost_done;
    logic [DIST_W-1:0] cost_nd;
    logic              improve;
    logic              wr_en;
    logic [NAW-1:0]    wr_addr;
    node_t             wr_data;
    logic [NAW-1:0]    rd_addr;
    logic              i_reach, i_has;

    assign op       = opcode_t'(in_op);
    assign in_edge  = '{decay: in_data[75:44], fixed: in_data[43:12],
                        dst: in_data[11:6], origin: in_data[5:0]};
    assign in_start = in_data[81:76];
    assign full     = total_reg >= ETW'(EDGE_CAPACITY);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (node_count_reg == '0)
            n_clamp = CNT_W'(1);
        else if (node_count_reg > CNT_W'(MAX_NODES))
            n_clamp = CNT_W'(MAX_NODES);
        else
            n_clamp = node_count_reg;
    end

    assign start_ok = {1'b0, start_reg} < n_reg;
    assign improve  = !reached_reg[edge_rd_reg.dst[NAW-1:0]]
                      || cost_nd < node_rd_reg.arrival;
    assign wr_en    = (cmd.run_init && start_ok) || (cmd.relax && improve);
    assign wr_addr  = cmd.run_init ? start_reg[NAW-1:0] : edge_rd_reg.dst[NAW-1:0];
    assign wr_data  = cmd.run_init ? node_t'('0)
                                   : node_t'{arrival: cost_nd, prev: best_idx_reg};
    assign rd_addr  = cmd.rd_dst ? edge_rd_reg.dst[NAW-1:0] : i_reg[NAW-1:0];

    assign st.scan_last  = {1'b0, i_reg} == n_reg - CNT_W'(1);
    assign st.best_valid = best_valid_reg;
    assign st.edge_done  = e_reg == total_reg;
    assign st.edge_match = edge_rd_reg.origin == best_idx_reg
                           && {1'b0, edge_rd_reg.dst} < n_reg;
    assign st.cost_done  = cost_done;
    assign st.out_free   = !out_valid_reg || out_ready;

    assign i_reach = reached_reg[i_reg[NAW-1:0]];
    assign i_has   = i_reach && i_reg != start_reg;

    tdsp_cost u_cost
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.cost_start),
        .t     (best_dist_reg),
        .c     (edge_rd_reg.fixed),
        .d     (edge_rd_reg.decay),
        .done  (cost_done),
        .nd    (cost_nd)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.accept && op == OP_ADD && !full)
            emem[total_reg[EAW-1:0]] <= in_edge;
        edge_rd_reg <= emem[e_reg[EAW-1:0]];
        if (wr_en)
            nmem[wr_addr] <= wr_data;
        node_rd_reg <= nmem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= CNT_W'(64);
            total_reg      <= '0;
            e_reg          <= '0;
            n_reg          <= CNT_W'(1);
            start_reg      <= '0;
            i_reg          <= '0;
            reached_reg    <= '0;
            fin_reg        <= '0;
            best_valid_reg <= 1'b0;
            best_idx_reg   <= '0;
            best_dist_reg  <= '0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
            out_user_reg   <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                node_count_reg <= cfg_data;
            if ((cmd.accept && op != OP_RUN) || cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (cmd.accept)
            begin
                n_reg     <= n_clamp;
                start_reg <= in_start;
                case (op)
                    OP_ADD:   if (!full) total_reg <= total_reg + ETW'(1);
                    OP_CLEAR: total_reg <= '0;
                    default:  ;
                endcase
                if (op != OP_RUN)
                begin
                    out_data_reg  <= '0;
                    out_user_reg  <= (op == OP_ADD) && full;
                    out_last_reg  <= 1'b1;
                end
            end
            if (cmd.run_init)
            begin
                fin_reg     <= '0;
                reached_reg <= start_ok ? MAX_NODES'(1) << start_reg[NAW-1:0] : '0;
            end
            else if (cmd.relax && improve)
                reached_reg[edge_rd_reg.dst[NAW-1:0]] <= 1'b1;
            if (cmd.scan_clr)
            begin
                i_reg          <= '0;
                best_valid_reg <= 1'b0;
            end
            else if (cmd.scan_step)
                i_reg <= i_reg + NODE_W'(1);
            if (cmd.best_cmp && i_reach && !fin_reg[i_reg[NAW-1:0]]
                && (!best_valid_reg || node_rd_reg.arrival < best_dist_reg))
            begin
                best_valid_reg <= 1'b1;
                best_idx_reg   <= i_reg;
                best_dist_reg  <= node_rd_reg.arrival;
            end
            if (cmd.fin_set)
                fin_reg[best_idx_reg[NAW-1:0]] <= 1'b1;
            if (cmd.edge_clr)
                e_reg <= '0;
            else if (cmd.edge_step)
                e_reg <= e_reg + ETW'(1);
            if (cmd.out_load)
            begin
                out_data_reg  <= {2'b0, i_has, i_has ? node_rd_reg.prev : NODE_W'(0),
                                  i_reach ? node_rd_reg.arrival : DIST_W'(0), i_reach, i_reg};
                out_user_reg  <= 1'b0;
                out_last_reg  <= st.scan_last;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_user  = out_user_reg;
    assign out_last  = out_last_reg;

    `include "time_dependent_shortest_path_defines.svh"

    `TDSP_ASSERT(a_total_cap, total_reg <= ETW'(EDGE_CAPACITY), "edge count over capacity")
    `TDSP_ASSERT(a_fin_reached, cmd.fin_set |-> reached_reg[best_idx_reg[NAW-1:0]],
        "settled node was never reached")
    `TDSP_ASSERT(a_wr_range, (cmd.relax && improve) |-> {1'b0, edge_rd_reg.dst} < n_reg,
        "relax outside nodes in use")
endmodule

FILE: rtl/tdsp_ctrl.sv
// ----------------------------------------------------------------------------
// tdsp_ctrl
// controller: item intake, node selection, edge scan and result sequencing
// ----------------------------------------------------------------------------
module tdsp_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        in_op,
    input  tdsp_pkg::status_t st,
    output tdsp_pkg::cmd_t    cmd
);
    import tdsp_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = (state_reg == S_IDLE) && st.out_free;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.accept = 1'b1;
                    if (opcode_t'(in_op) == OP_RUN)
                        state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                cmd.run_init = 1'b1;
                cmd.scan_clr = 1'b1;
                state_next   = S_SEL_RD;
            end
            S_SEL_RD:
                state_next = S_SEL_CMP;
            S_SEL_CMP:
            begin
                cmd.best_cmp = 1'b1;
                if (st.scan_last)
                    state_next = S_SEL_END;
                else
                begin
                    cmd.scan_step = 1'b1;
                    state_next    = S_SEL_RD;
                end
            end
            S_SEL_END:
            begin
                if (st.best_valid)
                begin
                    cmd.fin_set  = 1'b1;
                    cmd.edge_clr = 1'b1;
                    state_next   = S_EDGE_RD;
                end
                else
                begin
                    cmd.scan_clr = 1'b1;
                    state_next   = S_OUT_RD;
                end
            end
            S_EDGE_RD:
            begin
                if (st.edge_done)
                begin
                    cmd.scan_clr = 1'b1;
                    state_next   = S_SEL_RD;
                end
                else
                    state_next = S_EDGE_CHK;
            end
            S_EDGE_CHK:
            begin
                if (st.edge_match)
                begin
                    cmd.cost_start = 1'b1;
                    cmd.rd_dst     = 1'b1;
                    state_next     = S_COST_WAIT;
                end
                else
                begin
                    cmd.edge_step = 1'b1;
                    state_next    = S_EDGE_RD;
                end
            end
            S_COST_WAIT:
            begin
                cmd.rd_dst = 1'b1;
                if (st.cost_done)
                    state_next = S_RELAX;
            end
            S_RELAX:
            begin
                cmd.rd_dst    = 1'b1;
                cmd.relax     = 1'b1;
                cmd.edge_step = 1'b1;
                state_next    = S_EDGE_RD;
            end
            S_OUT_RD:
                state_next = S_OUT_LD;
            S_OUT_LD:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (st.scan_last)
                        state_next = S_IDLE;
                    else
                    begin
                        cmd.scan_step = 1'b1;
                        state_next    = S_OUT_RD;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    `include "time_dependent_shortest_path_defines.svh"

    `TDSP_ASSERT(a_ready_idle, in_ready |-> state_reg == S_IDLE, "ready outside idle")
    `TDSP_ASSERT_NEXT(a_cost_wait, cmd.cost_start, state_reg == S_COST_WAIT,
        "cost started without wait")
    `TDSP_ASSERT(a_relax_done, state_reg == S_RELAX |-> $past(st.cost_done),
        "relax before cost done")
endmodule
